@@ rtl/core/tpc_pkg.sv @@
package tpc_pkg;

   // register file
   localparam int CsrAddrWidth  = 4;
   localparam int CsrDataWidth  = 32;
   localparam int BaseWidth     = 8;
   localparam int LocWidth      = 7;
   localparam int BwWidth       = 20;
   localparam int UtilWidth     = 7;
   localparam int BoostWidth    = 8;
   localparam int PrioWidth     = 9;
   localparam int IoWidth       = 3;

   localparam int ReqDataWidth  = 88;
   localparam int ReqUserWidth  = 5;
   localparam int RspDataWidth  = 24;

   typedef enum logic [1:0] {
      REG_BASE_PRIO     = 2'd0,
      REG_LOCALITY_THR  = 2'd1,
      REG_BANDWIDTH_THR = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   localparam logic [BaseWidth-1:0] BaseReset = 8'd120;
   localparam logic [LocWidth-1:0]  LocReset  = 7'd80;
   localparam logic [BwWidth-1:0]   BwReset   = 20'd70;

   typedef enum logic [2:0] {
      CLS_UNKNOWN  = 3'd0,
      CLS_VECTORDB = 3'd1,
      CLS_KWORKER  = 3'd2,
      CLS_REGULAR  = 3'd3,
      CLS_LATENCY  = 3'd4,
      CLS_READ     = 3'd5,
      CLS_WRITE    = 3'd6,
      CLS_BWTEST   = 3'd7
   } task_class_type;

   localparam logic [IoWidth-1:0] IO_READ_HEAVY  = 3'd1;
   localparam logic [IoWidth-1:0] IO_WRITE_HEAVY = 3'd2;

   localparam logic [BwWidth-1:0]   VdbBwLimit     = 20'd1000;
   localparam logic [BwWidth-1:0]   BwtestBwLimit  = 20'd100;
   localparam logic [UtilWidth-1:0] UtilLimit      = 7'd90;
   localparam logic [LocWidth-1:0]  LowLocality    = 7'd30;
   localparam logic [BoostWidth-1:0] BoostDecay    = 8'd5;
   localparam logic [PrioWidth-1:0] PrioMax        = 9'd265;

   localparam logic [PrioWidth-1:0] AdjLocality  = 9'd20;
   localparam logic [PrioWidth-1:0] AdjSmall     = 9'd10;
   localparam logic [PrioWidth-1:0] AdjBandwidth = 9'd15;
   localparam logic [PrioWidth-1:0] AdjCritical  = 9'd30;
   localparam logic [PrioWidth-1:0] AdjLatency   = 9'd25;

   typedef struct packed {
      logic                  boost_pad;
      logic [BoostWidth-1:0] boost_in;
      logic                  wants_promotion;
      logic                  bandwidth_critical;
      logic [UtilWidth-1:0]  utilization;
      logic [BwWidth-1:0]    write_bw;
      logic [BwWidth-1:0]    read_bw;
      logic [BwWidth-1:0]    total_bandwidth;
      logic [IoWidth-1:0]    io_class;
      logic [LocWidth-1:0]   loc_score;
   } req_data_type;

   typedef struct packed {
      logic           metrics_valid;
      logic           pattern_valid;
      task_class_type task_class;
   } req_user_type;

   function automatic logic [PrioWidth-1:0] sat_sub(
      input logic [PrioWidth-1:0] a,
      input logic [PrioWidth-1:0] b
   );
      sat_sub = (a > b) ? (a - b) : '0;
   endfunction

endpackage

@@ rtl/core/task_priority_calculator_unit.sv @@
// Channel  Dir  Beat fields (low bit up)
// req_     in   tuser: task_class, pattern_valid, metrics_valid
//               tdata: loc_score, io_class, total_bandwidth, read_bw,
//                      write_bw, utilization, bandwidth_critical,
//                      wants_promotion, boost_in, 1 pad bit
// rsp_     out  tdata: priority_out, boost_out, 7 pad bits
// csr_     in   APB: 0x0 base_prio, 0x4 locality_threshold,
//               0x8 bw_threshold
//
// One beat per cycle while rsp_tready is high; a beat goes through the input
// register, then the result register, with the scoring logic between them.
// Synchronous active-high reset clears the valid bits and loads register
// defaults (120, 80, 70).
// Each stage holds when the one after it is full and stalled, so rsp_tready
// low backs up into req_tready after two beats.
module task_priority_calculator_unit
   import tpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,  // see table above
   input  logic [ReqUserWidth-1:0] req_tuser,  // task_class, pattern_valid, metrics_valid

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,  // priority_out, boost_out

   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic [BaseWidth-1:0] base_ff, base_in;
   logic [LocWidth-1:0]  loc_thr_ff, loc_thr_in;
   logic [BwWidth-1:0]   bw_thr_ff, bw_thr_in;
   logic                 csr_wr;
   reg_index_type        csr_idx;

   req_data_type         s1_data_ff;
   req_user_type         s1_user_ff;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_load;

   logic [PrioWidth-1:0]  s2_prio_ff, s2_prio_in;
   logic [BoostWidth-1:0] s2_boost_ff, s2_boost_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_load;

   logic [PrioWidth-1:0]  prio_adj;
   logic [PrioWidth-1:0]  boost_ext;
   logic                  pv, mv;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      base_in    = base_ff;
      loc_thr_in = loc_thr_ff;
      bw_thr_in  = bw_thr_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_BASE_PRIO:     base_in    = csr_pwdata[BaseWidth-1:0];
            REG_LOCALITY_THR:  loc_thr_in = csr_pwdata[LocWidth-1:0];
            REG_BANDWIDTH_THR: bw_thr_in  = csr_pwdata[BwWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_BASE_PRIO:     csr_prdata = {{(CsrDataWidth-BaseWidth){1'b0}}, base_ff};
         REG_LOCALITY_THR:  csr_prdata = {{(CsrDataWidth-LocWidth){1'b0}}, loc_thr_ff};
         REG_BANDWIDTH_THR: csr_prdata = {{(CsrDataWidth-BwWidth){1'b0}}, bw_thr_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BaseReset;
         loc_thr_ff <= LocReset;
         bw_thr_ff  <= BwReset;
      end else begin
         base_ff    <= base_in;
         loc_thr_ff <= loc_thr_in;
         bw_thr_ff  <= bw_thr_in;
      end
   end

   // pipeline handshake
   assign s2_load     = s1_valid_ff & (~s2_valid_ff | rsp_tready);
   assign req_tready  = ~s1_valid_ff | s2_load;
   assign s1_load     = req_tvalid & req_tready;
   assign s1_valid_in = s1_load | (s1_valid_ff & ~s2_load);
   assign s2_valid_in = s2_load | (s2_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data_type'(req_tdata);
         s1_user_ff <= req_user_type'(req_tuser);
      end
      if (s2_load) begin
         s2_prio_ff  <= s2_prio_in;
         s2_boost_ff <= s2_boost_in;
      end
   end

   // scoring
   assign pv = s1_user_ff.pattern_valid;
   assign mv = s1_user_ff.metrics_valid;

   always_comb begin
      prio_adj = {1'b0, base_ff};
      unique case (s1_user_ff.task_class)
         CLS_VECTORDB: begin
            if (pv && s1_data_ff.loc_score > loc_thr_ff)
               prio_adj = sat_sub(prio_adj, AdjLocality);
            if (mv && s1_data_ff.total_bandwidth > VdbBwLimit)
               prio_adj = sat_sub(prio_adj, AdjSmall);
         end
         CLS_READ: begin
            if (mv && s1_data_ff.read_bw > bw_thr_ff)
               prio_adj = sat_sub(prio_adj, AdjBandwidth);
            if (pv && s1_data_ff.io_class == IO_READ_HEAVY)
               prio_adj = sat_sub(prio_adj, AdjSmall);
         end
         CLS_WRITE: begin
            if (mv && s1_data_ff.write_bw > bw_thr_ff)
               prio_adj = sat_sub(prio_adj, AdjBandwidth);
            if (pv && s1_data_ff.io_class == IO_WRITE_HEAVY)
               prio_adj = sat_sub(prio_adj, AdjSmall);
         end
         CLS_BWTEST: begin
            if (s1_data_ff.bandwidth_critical)
               prio_adj = sat_sub(prio_adj, AdjCritical);
            if (pv && mv &&
                ((s1_data_ff.io_class == IO_READ_HEAVY &&
                  s1_data_ff.read_bw > BwtestBwLimit) ||
                 (s1_data_ff.io_class == IO_WRITE_HEAVY &&
                  s1_data_ff.write_bw > BwtestBwLimit)))
               prio_adj = sat_sub(prio_adj, AdjSmall);
         end
         CLS_KWORKER: begin
            if (s1_data_ff.wants_promotion)
               prio_adj = sat_sub(prio_adj, AdjBandwidth);
            if (mv && s1_data_ff.utilization > UtilLimit)
               prio_adj = prio_adj + AdjSmall;
         end
         CLS_LATENCY: prio_adj = sat_sub(prio_adj, AdjLatency);
         CLS_UNKNOWN, CLS_REGULAR: begin
            if (pv && s1_data_ff.loc_score < LowLocality)
               prio_adj = prio_adj + AdjSmall;
         end
         default: ;
      endcase
   end

   assign boost_ext = {1'b0, s1_data_ff.boost_in};

   always_comb begin
      s2_prio_in  = prio_adj;
      s2_boost_in = s1_data_ff.boost_in;
      if (s1_data_ff.boost_in != '0) begin
         // floor of 1 once a boost applies
         s2_prio_in  = (prio_adj > boost_ext) ? (prio_adj - boost_ext)
                                              : {{(PrioWidth-1){1'b0}}, 1'b1};
         s2_boost_in = (s1_data_ff.boost_in > BoostDecay)
                       ? (s1_data_ff.boost_in - BoostDecay) : '0;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-PrioWidth-BoostWidth){1'b0}},
                        s2_boost_ff, s2_prio_ff};

   // checks
   a_boost_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && s2_boost_ff != '0 |-> s2_prio_ff != '0)
      else $error("nonzero boost with zero priority");

   a_prio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> s2_prio_ff <= PrioMax)
      else $error("priority out of range");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted beat not captured");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && !rsp_tready |-> !req_tready)
      else $error("pipeline accepted while full");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_valid_ff |=> s2_valid_ff)
      else $error("stage one did not advance into empty result register");

endmodule
